// File: rtl/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// cpcr_pkg
// shared widths and the sideband word carried down the collision pipeline
// ----------------------------------------------------------------------------
package cpcr_pkg;

  localparam int POS_W    = 17;
  localparam int RAD_W    = 12;
  localparam int GAIN_W   = 8;
  localparam int GAIN_FRAC = 6;
  localparam int DIFF_W   = POS_W + 1;
  localparam int SQ_W     = 2 * DIFF_W - 2;
  localparam int DIAM_W   = RAD_W + 1;
  localparam int DSQ_W    = 2 * DIAM_W;
  localparam int ROOT_W   = DIAM_W;
  localparam int MAG_W    = DIAM_W;
  localparam int PROD_W   = MAG_W + GAIN_W;
  localparam int NUM_W    = PROD_W + DIAM_W;
  localparam int QUO_W    = 14;
  localparam int DVD_W    = NUM_W - (GAIN_FRAC + 1);
  localparam int CORR_W   = QUO_W + 2;

  localparam logic [0:0] REG_RADIUS = 1'b0;
  localparam logic [0:0] REG_GAIN   = 1'b1;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(320);
  localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(64);

  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

  typedef struct packed {
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    logic signed [POS_W-1:0] x2;
    logic signed [POS_W-1:0] y2;
    logic [MAG_W-1:0]        mag_x;
    logic [MAG_W-1:0]        mag_y;
    logic                    neg_x;
    logic                    neg_y;
    logic                    ovl;
    logic                    coin;
    logic [ROOT_W-1:0]       distance;
  } side_t;

endpackage

// File: rtl/cpcr_front.sv
// ----------------------------------------------------------------------------
// cpcr_front
// difference vector, squares, squared distance and overlap test
// ----------------------------------------------------------------------------
module cpcr_front
  import cpcr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [RAD_W-1:0]        radius,
  input  logic                    valid_in,
  input  logic signed [POS_W-1:0] first_x,
  input  logic signed [POS_W-1:0] first_y,
  input  logic signed [POS_W-1:0] second_x,
  input  logic signed [POS_W-1:0] second_y,
  output logic                    valid_out,
  output side_t                   side_out,
  output logic [2*ROOT_W-1:0]     root_arg
);

  logic                      v1, v2, v3;
  side_t                     s1, s2;
  side_t                     s1_next, s2_next, side_next;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [SQ_W-1:0]           sq_x, sq_y;
  logic [DSQ_W-1:0]          diam_sq;
  logic [DIAM_W-1:0]         diam;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  logic [SQ_W:0]             dist2;

  always_comb begin
    diam   = {radius, 1'b0};
    prod_x = dx * dx;
    prod_y = dy * dy;
    dist2  = {1'b0, sq_x} + {1'b0, sq_y};

    s1_next    = '0;
    s1_next.x1 = first_x;
    s1_next.y1 = first_y;
    s1_next.x2 = second_x;
    s1_next.y2 = second_y;

    s2_next       = s1;
    s2_next.mag_x = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    s2_next.mag_y = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    s2_next.neg_x = dx[DIFF_W-1];
    s2_next.neg_y = dy[DIFF_W-1];
    s2_next.coin  = (dx == '0) && (dy == '0);

    side_next     = s2;
    side_next.ovl = dist2 < (SQ_W+1)'(diam_sq);
  end

  always_ff @(posedge clk) begin
    diam_sq <= diam * diam;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      s1       <= s1_next;
      dx       <= DIFF_W'(first_x) - DIFF_W'(second_x);
      dy       <= DIFF_W'(first_y) - DIFF_W'(second_y);
      s2       <= s2_next;
      sq_x     <= prod_x[SQ_W-1:0];
      sq_y     <= prod_y[SQ_W-1:0];
      side_out <= side_next;
      root_arg <= dist2[2*ROOT_W-1:0];
    end
  end

  assign valid_out = v3;

endmodule

// File: rtl/cpcr_isqrt.sv
// ----------------------------------------------------------------------------
// cpcr_isqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module cpcr_isqrt
  import cpcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  side_t               side_in,
  input  logic [2*ROOT_W-1:0] root_arg,
  output logic                valid_out,
  output side_t               side_out
);

  localparam int REM_W = ROOT_W + 2;

  logic [2*ROOT_W-1:0] arg  [0:ROOT_W];
  logic [REM_W-1:0]    rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   root [0:ROOT_W];
  side_t               side [0:ROOT_W];
  logic                vld  [0:ROOT_W];

  always_comb begin
    arg[0]  = root_arg;
    rem[0]  = '0;
    root[0] = '0;
    side[0] = side_in;
    vld[0]  = valid_in;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int I = ROOT_W - 1 - k;
    logic [REM_W+1:0] trial_rem;
    logic [REM_W+1:0] trial_sub;
    logic             fits;

    always_comb begin
      trial_rem = {rem[k], arg[k][2*I+1 -: 2]};
      trial_sub = {2'b00, root[k], 2'b01};
      fits      = trial_rem >= trial_sub;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        arg[k+1]  <= arg[k];
        side[k+1] <= side[k];
        rem[k+1]  <= fits ? REM_W'(trial_rem - trial_sub) : REM_W'(trial_rem);
        root[k+1] <= {root[k][ROOT_W-2:0], fits};
      end
    end
  end

  always_comb begin
    side_out          = side[ROOT_W];
    side_out.distance = root[ROOT_W];
    valid_out         = vld[ROOT_W];
  end

endmodule

// File: rtl/cpcr_scale.sv
// ----------------------------------------------------------------------------
// cpcr_scale
// overlap, gain and magnitude products, rounded dividend
// ----------------------------------------------------------------------------
module cpcr_scale
  import cpcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [RAD_W-1:0]   radius,
  input  logic [GAIN_W-1:0]  gain,
  input  logic               valid_in,
  input  side_t              side_in,
  output logic               valid_out,
  output side_t              side_out,
  output logic [DVD_W-1:0]   dvd_x,
  output logic [DVD_W-1:0]   dvd_y
);

  logic              va, vb, vc;
  side_t             sa, sb;
  logic [PROD_W-1:0] px, py;
  logic [DIAM_W-1:0] overlap;
  logic [NUM_W-1:0]  nx, ny;
  logic [NUM_W-1:0]  rx, ry;
  logic [NUM_W-1:0]  half;

  always_comb begin
    half = NUM_W'({sb.distance, GAIN_FRAC'(0)});
    rx   = nx + half;
    ry   = ny + half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= valid_in;
      vb <= va;
      vc <= vb;
    end
    if (en) begin
      sa       <= side_in;
      px       <= side_in.mag_x * gain;
      py       <= side_in.mag_y * gain;
      overlap  <= {radius, 1'b0} - side_in.distance;
      sb       <= sa;
      nx       <= px * overlap;
      ny       <= py * overlap;
      side_out <= sb;
      dvd_x    <= rx[NUM_W-1:GAIN_FRAC+1];
      dvd_y    <= ry[NUM_W-1:GAIN_FRAC+1];
    end
  end

  assign valid_out = vc;

endmodule

// File: rtl/cpcr_div.sv
// ----------------------------------------------------------------------------
// cpcr_div
// two-lane pipelined restoring divider by the distance, one quotient bit per stage
// ----------------------------------------------------------------------------
module cpcr_div
  import cpcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  side_t             side_in,
  input  logic [DVD_W-1:0]  dvd_x,
  input  logic [DVD_W-1:0]  dvd_y,
  output logic              valid_out,
  output side_t             side_out,
  output logic [QUO_W-1:0]  quo_x,
  output logic [QUO_W-1:0]  quo_y
);

  logic [DVD_W-1:0]  dvd  [0:QUO_W][0:1];
  logic [ROOT_W-1:0] rem  [0:QUO_W][0:1];
  logic [QUO_W-1:0]  quo  [0:QUO_W][0:1];
  side_t             side [0:QUO_W];
  logic              vld  [0:QUO_W];

  always_comb begin
    dvd[0][0] = dvd_x;
    dvd[0][1] = dvd_y;
    rem[0][0] = dvd_x[DVD_W-1 -: ROOT_W];
    rem[0][1] = dvd_y[DVD_W-1 -: ROOT_W];
    quo[0][0] = '0;
    quo[0][1] = '0;
    side[0]   = side_in;
    vld[0]    = valid_in;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int I = QUO_W - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        side[k+1] <= side[k];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [ROOT_W:0] trial;
      logic            fits;

      always_comb begin
        trial = {rem[k][l], dvd[k][l][I]};
        fits  = trial >= {1'b0, side[k].distance};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dvd[k+1][l] <= dvd[k][l];
          rem[k+1][l] <= fits ? ROOT_W'(trial - {1'b0, side[k].distance}) : ROOT_W'(trial);
          quo[k+1][l] <= {quo[k][l][QUO_W-2:0], fits};
        end
      end
    end
  end

  always_comb begin
    valid_out = vld[QUO_W];
    side_out  = side[QUO_W];
    quo_x     = quo[QUO_W][0];
    quo_y     = quo[QUO_W][1];
  end

endmodule

// File: rtl/circle_pair_collision_resolve.sv
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve
// pushes two overlapping equal-radius circles apart by gain/64 times half the overlap
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_stall    first_x first_y second_x second_y
//  out      out_valid/out_stall  overlapping coincident moved_*
//  cfg      cfg_write            cfg_index cfg_data
//
// one word per cycle sustained while the output is not stalled; stages: 3 front, 13 square
// root, 3 scale, 14 divide, 1 output stage
// the whole pipeline advances together; out_stall on a full output
// register holds every stage and raises in_stall in the same cycle
// rst clears valid bits and loads radius 320 and gain 64
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve
  import cpcr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [0:0]               cfg_index,
  input  logic [RAD_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [POS_W-1:0]  first_x,
  input  logic signed [POS_W-1:0]  first_y,
  input  logic signed [POS_W-1:0]  second_x,
  input  logic signed [POS_W-1:0]  second_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     overlapping,
  output logic                     coincident,
  output logic signed [POS_W-1:0]  moved_first_x,
  output logic signed [POS_W-1:0]  moved_first_y,
  output logic signed [POS_W-1:0]  moved_second_x,
  output logic signed [POS_W-1:0]  moved_second_y
);

  logic [RAD_W-1:0]  radius;
  logic [GAIN_W-1:0] gain;
  logic              adv;

  logic                front_valid, root_valid, scale_valid, div_valid;
  side_t               front_side, root_side, scale_side, div_side;
  logic [2*ROOT_W-1:0] root_arg;
  logic [DVD_W-1:0]    dvd_x, dvd_y;
  logic [QUO_W-1:0]    quo_x, quo_y;

  logic signed [CORR_W-1:0] corr_x, corr_y;
  logic                     apply;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      gain   <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIUS: radius <= cfg_data;
        REG_GAIN:   gain   <= cfg_data[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  cpcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .radius    (radius),
    .valid_in  (in_valid),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .valid_out (front_valid),
    .side_out  (front_side),
    .root_arg  (root_arg)
  );

  cpcr_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (front_valid),
    .side_in   (front_side),
    .root_arg  (root_arg),
    .valid_out (root_valid),
    .side_out  (root_side)
  );

  cpcr_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .radius    (radius),
    .gain      (gain),
    .valid_in  (root_valid),
    .side_in   (root_side),
    .valid_out (scale_valid),
    .side_out  (scale_side),
    .dvd_x     (dvd_x),
    .dvd_y     (dvd_y)
  );

  cpcr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (scale_valid),
    .side_in   (scale_side),
    .dvd_x     (dvd_x),
    .dvd_y     (dvd_y),
    .valid_out (div_valid),
    .side_out  (div_side),
    .quo_x     (quo_x),
    .quo_y     (quo_y)
  );

  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0]  pos,
    input logic signed [CORR_W-1:0] corr
  );
    logic signed [DIFF_W:0] sum;
    sum = (DIFF_W+1)'(pos) + (DIFF_W+1)'(corr);
    if (sum < (DIFF_W+1)'(POS_MIN)) begin
      return POS_MIN;
    end else if (sum > (DIFF_W+1)'(POS_MAX)) begin
      return POS_MAX;
    end
    return sum[POS_W-1:0];
  endfunction

  always_comb begin
    corr_x = div_side.neg_x ? -CORR_W'(quo_x) : CORR_W'(quo_x);
    corr_y = div_side.neg_y ? -CORR_W'(quo_y) : CORR_W'(quo_y);
    apply  = div_side.ovl && !div_side.coin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_valid;
    end
    if (adv) begin
      overlapping <= div_side.ovl;
      coincident  <= div_side.coin;
      if (apply) begin
        moved_first_x  <= sat_add(div_side.x1, corr_x);
        moved_first_y  <= sat_add(div_side.y1, corr_y);
        moved_second_x <= sat_add(div_side.x2, -corr_x);
        moved_second_y <= sat_add(div_side.y2, -corr_y);
      end else begin
        moved_first_x  <= div_side.x1;
        moved_first_y  <= div_side.y1;
        moved_second_x <= div_side.x2;
        moved_second_y <= div_side.y2;
      end
    end
  end

  // coincident centers always sit inside a nonzero diameter
  a_coin_ovl: assert property (@(posedge clk) disable iff (rst)
    out_valid && coincident && (radius != '0) |-> overlapping)
    else $error("coincident pair not flagged overlapping");

  // no word leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a held output keeps the whole pipeline frozen
  a_hold_front: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(front_side) && $stable(div_side))
    else $error("pipeline moved during output stall");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// random and directed circle pairs against a bit-exact overlap and moved-position predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import cpcr_pkg::*;

typedef struct {
  logic                    ovl;
  logic                    coin;
  logic signed [POS_W-1:0] fx;
  logic signed [POS_W-1:0] fy;
  logic signed [POS_W-1:0] sx;
  logic signed [POS_W-1:0] sy;
} pair_result_t;

class pair_scoreboard;
  longint unsigned radius;
  longint unsigned gain;
  pair_result_t    pending[$];
  int              mismatches;

  function new();
    radius = 320;
    gain = 64;
    mismatches = 0;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function longint push_amount(longint d, longint unsigned ovr, longint unsigned dlen);
    longint unsigned mag, num, den, q;
    mag = (d < 0) ? -d : d;
    num = mag * gain * ovr;
    den = 2 * 64 * dlen;
    q = (2 * num + den) / (2 * den);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function logic signed [POS_W-1:0] clamp(longint v);
    if (v < -65536) return POS_MIN;
    if (v > 65535) return POS_MAX;
    return v[POS_W-1:0];
  endfunction

  function void note_pair(logic signed [POS_W-1:0] x1, y1, x2, y2);
    longint a, b, c, d, dx, dy, cx, cy;
    longint unsigned d2, diam, dlen;
    pair_result_t r;
    a = x1; b = y1; c = x2; d = y2;
    dx = a - c;
    dy = b - d;
    d2 = dx * dx + dy * dy;
    diam = 2 * radius;
    r.ovl = d2 < diam * diam;
    r.coin = (dx == 0) && (dy == 0);
    r.fx = x1; r.fy = y1; r.sx = x2; r.sy = y2;
    if (r.ovl && !r.coin) begin
      dlen = int_sqrt(d2);
      cx = push_amount(dx, diam - dlen, dlen);
      cy = push_amount(dy, diam - dlen, dlen);
      r.fx = clamp(a + cx);
      r.fy = clamp(b + cy);
      r.sx = clamp(c - cx);
      r.sy = clamp(d - cy);
    end
    pending = {pending, r};
  endfunction

  function void check_result(pair_result_t got);
    pair_result_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output word");
      return;
    end
    e = pending.pop_front();
    if (got.ovl !== e.ovl || got.coin !== e.coin || got.fx !== e.fx ||
        got.fy !== e.fy || got.sx !== e.sx || got.sy !== e.sy) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp %0b %0b %0d %0d %0d %0d got %0b %0b %0d %0d %0d %0d",
                 e.ovl, e.coin, e.fx, e.fy, e.sx, e.sy,
                 got.ovl, got.coin, got.fx, got.fy, got.sx, got.sy);
    end
  endfunction
endclass

module tb_top;
  localparam int XMAX = int'(POS_MAX);
  localparam int XMIN = int'(POS_MIN);

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    cfg_write = 0;
  logic [0:0]              cfg_index = REG_RADIUS;
  logic [RAD_W-1:0]        cfg_data = '0;
  logic                    in_valid = 0;
  logic                    in_stall;
  logic signed [POS_W-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic                    out_valid;
  logic                    out_stall = 0;
  logic                    overlapping, coincident;
  logic signed [POS_W-1:0] moved_first_x, moved_first_y, moved_second_x, moved_second_y;

  pair_scoreboard sb = new();
  longint unsigned cycles = 0;

  circle_pair_collision_resolve dut (.*);

  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 95) return int'($urandom_range(1, 3));
    return int'($urandom_range(4, 40));
  endfunction

  always @(posedge clk) begin
    pair_result_t got;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got.ovl = overlapping; got.coin = coincident;
      got.fx = moved_first_x; got.fy = moved_first_y;
      got.sx = moved_second_x; got.sy = moved_second_y;
      sb.check_result(got);
    end
  end

  // output stall: bursts of stall of random length, sometimes none
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      n = int'($urandom_range(1, 20));
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_pair(int x1, y1, x2, y2, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    first_x <= POS_W'(x1); first_y <= POS_W'(y1);
    second_x <= POS_W'(x2); second_y <= POS_W'(y2);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pair(POS_W'(x1), POS_W'(y1), POS_W'(x2), POS_W'(y2));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int unsigned val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= RAD_W'(val);
    @(posedge clk);
    cfg_write <= 0;
    if (idx == REG_RADIUS) sb.radius = val & 12'hFFF;
    else sb.gain = val & 8'hFF;
  endtask

  function automatic int rnd_pos();
    return int'($urandom_range(0, 131071));
  endfunction

  task automatic random_pairs(int count);
    int x1, y1, dx, dy;
    int span, mode;
    for (int i = 0; i < count; i++) begin
      mode = int'($urandom_range(0, 9));
      x1 = rnd_pos();
      y1 = rnd_pos();
      span = int'(4 * sb.radius + 2);
      if (mode < 7) begin
        dx = int'($urandom_range(0, span)) - span / 2;
        dy = int'($urandom_range(0, span)) - span / 2;
        send_pair(x1, y1, x1 - dx, y1 - dy, 1);
      end else if (mode == 7) begin
        send_pair(x1, y1, x1, y1, 1);
      end else begin
        send_pair(x1, y1, rnd_pos(), rnd_pos(), 1);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset registers
    send_pair(0, 0, 0, 0, 0);
    send_pair(100, 0, 0, 0, 0);
    send_pair(0, -300, 0, 300, 0);
    send_pair(XMAX, XMAX, XMAX - 10, XMAX - 5, 0);
    send_pair(XMIN, XMIN, XMIN + 7, XMIN + 1, 0);
    send_pair(XMAX, XMIN, XMIN, XMAX, 0);
    send_pair(XMIN, 0, XMAX, 0, 0);
    send_pair(639, 0, 0, 0, 0);
    send_pair(640, 0, 0, 0, 0);
    send_pair(1, 1, 0, 0, 0);
    send_pair(-5, 3, 5, -3, 0);
    drain();
    write_reg(REG_GAIN, 0);
    write_reg(REG_RADIUS, 4095);
    send_pair(10, 10, -20, 30, 0);
    send_pair(XMAX, 0, XMAX - 1, 0, 0);
    drain();
    write_reg(REG_GAIN, 255);
    send_pair(XMAX, XMAX, XMAX - 1, XMAX - 1, 0);
    send_pair(XMIN, XMIN, XMIN + 3, XMIN + 2, 0);
    send_pair(0, 0, 8000, -100, 0);
    drain();
    write_reg(REG_RADIUS, 0);
    write_reg(REG_GAIN, 128);
    send_pair(0, 0, 0, 0, 0);
    send_pair(1, 0, 0, 0, 0);
    drain();

    // random phases over several settings
    write_reg(REG_RADIUS, 320);  write_reg(REG_GAIN, 64);  random_pairs(200);
    drain();
    write_reg(REG_RADIUS, 64);   write_reg(REG_GAIN, 128); random_pairs(200);
    drain();
    write_reg(REG_RADIUS, 4095); write_reg(REG_GAIN, 255); random_pairs(200);
    drain();
    write_reg(REG_RADIUS, $urandom_range(64, 4095));
    write_reg(REG_GAIN, $urandom_range(0, 255));
    random_pairs(200);
    drain();
    write_reg(REG_RADIUS, $urandom_range(1, 2000));
    write_reg(REG_GAIN, $urandom_range(1, 128));
    random_pairs(230);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
